// ===== hw/rtl/wcg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package wcg_pkg;

   localparam int MAX_LENGTH     = 4096;
   localparam int COEF_FRAC_BITS = 16;

   localparam int INDEX_W = 12;
   localparam int LEN_W   = 13;
   localparam int COEF_W  = 18;
   localparam int TURN_W  = 32;
   localparam int DATA_W  = 13;

   localparam logic [30:0] Q30_ONE = 31'h4000_0000;
   localparam logic [31:0] PI_Q30  = 32'd3373259426;

   typedef enum logic [1:0] {
      WIN_HANN     = 2'd0,
      WIN_HAMMING  = 2'd1,
      WIN_BLACKMAN = 2'd2
   } wcg_window_type;

   localparam logic CSR_WINDOW_TYPE   = 1'b0;
   localparam logic CSR_WINDOW_LENGTH = 1'b1;

   typedef struct packed {
      logic       valid;
      logic       err;
      logic       len1;
      logic [1:0] wtype;
   } wcg_tag_type;

   // Horner steps of the octant polynomials; divides by the step constants
   // go through exact reciprocals: m = ceil(2^(30+l) / d), 2^(l-1) < d <= 2^l
   localparam int HORNER_STEPS = 5;

   localparam logic [31:0] HORNER_MUL [2][HORNER_STEPS] = '{
      '{32'(((64'd1 << 37) + 64'd89) / 64'd90),
        32'(((64'd1 << 36) + 64'd55) / 64'd56),
        32'(((64'd1 << 35) + 64'd29) / 64'd30),
        32'(((64'd1 << 34) + 64'd11) / 64'd12),
        32'(((64'd1 << 31) + 64'd1) / 64'd2)},
      '{32'(((64'd1 << 37) + 64'd109) / 64'd110),
        32'(((64'd1 << 37) + 64'd71) / 64'd72),
        32'(((64'd1 << 36) + 64'd41) / 64'd42),
        32'(((64'd1 << 35) + 64'd19) / 64'd20),
        32'(((64'd1 << 33) + 64'd5) / 64'd6)}
   };

   localparam int HORNER_SHIFT [2][HORNER_STEPS] = '{
      '{37, 36, 35, 34, 31},
      '{37, 37, 36, 35, 33}
   };

   // output scaling: divide the weighted Q30 sum by 100 * 2^ROUND_SHIFT
   localparam int ROUND_SHIFT = 30 - COEF_FRAC_BITS;
   localparam logic [38:0] ROUND_BIAS = 39'(50) << ROUND_SHIFT;
   localparam int DIVQ_N     = 39 - ROUND_SHIFT;
   localparam int DIVQ_SHIFT = DIVQ_N + 7;
   localparam logic [63:0] DIV_MUL = ((64'd1 << DIVQ_SHIFT) + 64'd99) / 64'd100;

   localparam int COEF_MAX = (2 ** (COEF_W - 1)) - 1;
   localparam int COEF_MIN_MAG = 2 ** (COEF_W - 1);
   localparam logic signed [COEF_W-1:0] LEN1_COEF =
      (COEF_FRAC_BITS >= COEF_W - 1) ? COEF_W'(COEF_MAX) : COEF_W'(1 << COEF_FRAC_BITS);

endpackage

`default_nettype wire

// ===== hw/rtl/wcg_phase_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wcg_phase_div
   import wcg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [INDEX_W-1:0] sample_index,
   input  wire logic [LEN_W-1:0]   window_length,
   input  wire logic [1:0]         window_type,
   output      logic [TURN_W-1:0]  turn,
   output      wcg_tag_type        tag
);

   localparam int DIV_STAGES = 4;
   localparam int STEPS      = TURN_W / DIV_STAGES;

   logic [12:0]       rem_ff [DIV_STAGES+1];
   logic [12:0]       rem_in [DIV_STAGES+1];
   logic [TURN_W-1:0] q_ff   [DIV_STAGES+1];
   logic [TURN_W-1:0] q_in   [DIV_STAGES+1];
   logic [11:0]       d_ff   [DIV_STAGES+1];
   logic [11:0]       d_in;
   wcg_tag_type       tag_ff [DIV_STAGES+1];
   wcg_tag_type       tag_in;

   // first step takes the 2^32 quotient bit, which wraps away
   always_comb begin
      d_in         = 12'(window_length - LEN_W'(1));
      tag_in.valid = in_valid;
      tag_in.err   = {1'b0, sample_index} >= window_length;
      tag_in.len1  = window_length == LEN_W'(1);
      tag_in.wtype = window_type;
      rem_in[0]    = {1'b0, sample_index};
      if (rem_in[0] >= {1'b0, d_in}) begin
         rem_in[0] = rem_in[0] - {1'b0, d_in};
      end
      q_in[0] = '0;
   end

   for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_div
      always_comb begin
         rem_in[s] = rem_ff[s-1];
         q_in[s]   = q_ff[s-1];
         for (int j = 0; j < STEPS; j++) begin
            rem_in[s] = {rem_in[s][11:0], 1'b0};
            if (rem_in[s] >= {1'b0, d_ff[s-1]}) begin
               rem_in[s] = rem_in[s] - {1'b0, d_ff[s-1]};
               q_in[s]   = {q_in[s][TURN_W-2:0], 1'b1};
            end else begin
               q_in[s]   = {q_in[s][TURN_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in[0];
      q_ff[0]   <= q_in[0];
      d_ff[0]   <= d_in;
      for (int s = 1; s <= DIV_STAGES; s++) begin
         rem_ff[s] <= rem_in[s];
         q_ff[s]   <= q_in[s];
         d_ff[s]   <= d_ff[s-1];
      end
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            tag_ff[s].valid <= 1'b0;
         end
      end else begin
         tag_ff[0] <= tag_in;
         for (int s = 1; s <= DIV_STAGES; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
      end
   end

   assign turn = q_ff[DIV_STAGES];
   assign tag  = tag_ff[DIV_STAGES];

endmodule

`default_nettype wire

// ===== hw/rtl/wcg_trig_pipe.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wcg_trig_pipe
   import wcg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [TURN_W-1:0]  turn,
   input  wire wcg_tag_type        in_tag,
   output      logic signed [31:0] cos1,
   output      logic signed [31:0] cos2,
   output      wcg_tag_type        out_tag
);

   localparam int HSTAGES = 2 * HORNER_STEPS;

   typedef struct packed {
      wcg_tag_type      tag;
      logic [1:0][1:0]  quad;
      logic [1:0]       swap;
      logic [1:0][29:0] x;
      logic [1:0][29:0] x2;
   } wcg_side_type;

   logic [TURN_W-1:0] ang [2];

   // lane 0 works on t, lane 1 on 2t
   assign ang[0] = turn;
   assign ang[1] = {turn[TURN_W-2:0], 1'b0};

   wcg_tag_type     p1_tag_ff, p2_tag_ff;
   logic [1:0][1:0] p1_quad_ff, p2_quad_ff;
   logic [1:0]      p1_swap_ff, p2_swap_ff;
   logic [29:0]     p1_r_ff [2];
   logic [29:0]     p1_r_in [2];
   logic [29:0]     p2_x_ff [2];
   logic [61:0]     p2_prod [2];
   logic [59:0]     p3_prod [2];

   wcg_side_type    sd_ff [HSTAGES+1];
   wcg_side_type    sd_in;

   logic [29:0]     p_ff [2][2][HORNER_STEPS];
   logic [29:0]     q_ff [2][2][HORNER_STEPS];
   logic [30:0]     t_k  [2][2][HORNER_STEPS];
   logic [60:0]     a_prod [2][2][HORNER_STEPS];
   logic [61:0]     b_prod [2][2][HORNER_STEPS];

   logic [30:0]     f_cv_ff [2];
   logic [30:0]     f_sv_ff [2];
   logic [30:0]     f_st    [2];
   logic [60:0]     f_prod  [2];
   logic [1:0][1:0] f_quad_ff;
   logic [1:0]      f_swap_ff;
   wcg_tag_type     f_tag_ff;

   logic signed [31:0] g_c_ff [2];
   logic signed [31:0] g_c_in [2];
   logic [30:0]        g_cosv [2];
   logic [30:0]        g_sinv [2];
   wcg_tag_type        g_tag_ff;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      // fold the upper half octant onto the lower one
      always_comb begin
         if (ang[l][29]) begin
            p1_r_in[l] = 30'd0 - ang[l][29:0];
         end else begin
            p1_r_in[l] = ang[l][29:0];
         end
      end

      assign p2_prod[l] = p1_r_ff[l] * PI_Q30;
      assign p3_prod[l] = p2_x_ff[l] * p2_x_ff[l];

      for (genvar c = 0; c < 2; c++) begin : g_chain
         for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_step
            if (k == 0) begin : g_first
               assign t_k[l][c][k] = Q30_ONE;
            end else begin : g_next
               assign t_k[l][c][k] = Q30_ONE - {1'b0, q_ff[l][c][k-1]};
            end
            assign a_prod[l][c][k] = sd_ff[2*k].x2[l] * t_k[l][c][k];
            assign b_prod[l][c][k] = p_ff[l][c][k] * HORNER_MUL[c][k];

            always_ff @(posedge clock) begin
               p_ff[l][c][k] <= a_prod[l][c][k][59:30];
               q_ff[l][c][k] <= 30'(b_prod[l][c][k] >> HORNER_SHIFT[c][k]);
            end
         end
      end

      assign f_st[l]   = Q30_ONE - {1'b0, q_ff[l][1][HORNER_STEPS-1]};
      assign f_prod[l] = sd_ff[HSTAGES].x[l] * f_st[l];

      always_comb begin
         g_cosv[l] = f_swap_ff[l] ? f_sv_ff[l] : f_cv_ff[l];
         g_sinv[l] = f_swap_ff[l] ? f_cv_ff[l] : f_sv_ff[l];
         unique case (f_quad_ff[l])
            2'd0:    g_c_in[l] = $signed({1'b0, g_cosv[l]});
            2'd1:    g_c_in[l] = -$signed({1'b0, g_sinv[l]});
            2'd2:    g_c_in[l] = -$signed({1'b0, g_cosv[l]});
            default: g_c_in[l] = $signed({1'b0, g_sinv[l]});
         endcase
      end

      always_ff @(posedge clock) begin
         p1_r_ff[l] <= p1_r_in[l];
         p2_x_ff[l] <= p2_prod[l][60:31];
         f_cv_ff[l] <= Q30_ONE - {1'b0, q_ff[l][0][HORNER_STEPS-1]};
         f_sv_ff[l] <= f_prod[l][60:30];
         g_c_ff[l]  <= g_c_in[l];
      end
   end

   always_comb begin
      sd_in.tag  = p2_tag_ff;
      sd_in.quad = p2_quad_ff;
      sd_in.swap = p2_swap_ff;
      for (int l = 0; l < 2; l++) begin
         sd_in.x[l]  = p2_x_ff[l];
         sd_in.x2[l] = p3_prod[l][59:30];
      end
   end

   always_ff @(posedge clock) begin
      p1_quad_ff <= {ang[1][31:30], ang[0][31:30]};
      p1_swap_ff <= {ang[1][29], ang[0][29]};
      p2_quad_ff <= p1_quad_ff;
      p2_swap_ff <= p1_swap_ff;
      f_quad_ff  <= sd_ff[HSTAGES].quad;
      f_swap_ff  <= sd_ff[HSTAGES].swap;
      if (reset) begin
         p1_tag_ff.valid <= 1'b0;
         p2_tag_ff.valid <= 1'b0;
         for (int h = 0; h <= HSTAGES; h++) begin
            sd_ff[h].tag.valid <= 1'b0;
         end
         f_tag_ff.valid <= 1'b0;
         g_tag_ff.valid <= 1'b0;
      end else begin
         p1_tag_ff <= in_tag;
         p2_tag_ff <= p1_tag_ff;
         sd_ff[0]  <= sd_in;
         for (int h = 1; h <= HSTAGES; h++) begin
            sd_ff[h] <= sd_ff[h-1];
         end
         f_tag_ff  <= sd_ff[HSTAGES].tag;
         g_tag_ff  <= f_tag_ff;
      end
   end

   assign cos1    = g_c_ff[0];
   assign cos2    = g_c_ff[1];
   assign out_tag = g_tag_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/wcg_combine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module wcg_combine
   import wcg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic signed [31:0]       cos1,
   input  wire logic signed [31:0]       cos2,
   input  wire wcg_tag_type              in_tag,
   output      logic                     out_valid,
   output      logic signed [COEF_W-1:0] out_coefficient,
   output      logic                     out_index_error
);

   localparam logic signed [38:0] W_ONE = 39'sd1 <<< 30;

   logic signed [38:0] cw, c2w;
   logic signed [38:0] w_ff, w_in;
   wcg_tag_type        w_tag_ff;

   logic [37:0]        mag;
   logic [38:0]        biased;
   logic [DIVQ_N-1:0]  a_ff;
   logic               a_neg_ff;
   wcg_tag_type        a_tag_ff;

   logic [2*DIVQ_N:0]  dprod;
   logic [DIVQ_N-1:0]  q_ff;
   logic               q_neg_ff;
   wcg_tag_type        q_tag_ff;

   logic signed [COEF_W-1:0] coef_in;
   logic signed [COEF_W-1:0] coef_ff;
   logic                     valid_ff;
   logic                     err_ff;

   always_comb begin
      cw  = 39'(cos1);
      c2w = 39'(cos2);
      unique case (in_tag.wtype)
         WIN_HANN:    w_in = 39'sd50 * W_ONE - 39'sd50 * cw;
         WIN_HAMMING: w_in = 39'sd54 * W_ONE - 39'sd46 * cw;
         default:     w_in = 39'sd42 * W_ONE - 39'sd50 * cw + 39'sd8 * c2w;
      endcase
   end

   // round half away from zero on the magnitude
   always_comb begin
      mag    = 38'(w_ff[38] ? -w_ff : w_ff);
      biased = {1'b0, mag} + ROUND_BIAS;
   end

   assign dprod = a_ff * DIV_MUL[DIVQ_N:0];

   always_comb begin
      if (q_tag_ff.err) begin
         coef_in = '0;
      end else if (q_tag_ff.len1) begin
         coef_in = LEN1_COEF;
      end else if (q_neg_ff) begin
         if (q_ff > DIVQ_N'(COEF_MIN_MAG)) begin
            coef_in = COEF_W'(-COEF_MIN_MAG);
         end else begin
            coef_in = -$signed(COEF_W'(q_ff));
         end
      end else if (q_ff > DIVQ_N'(COEF_MAX)) begin
         coef_in = COEF_W'(COEF_MAX);
      end else begin
         coef_in = $signed(COEF_W'(q_ff));
      end
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      a_ff     <= DIVQ_N'(biased >> ROUND_SHIFT);
      a_neg_ff <= w_ff[38];
      q_ff     <= DIVQ_N'(dprod >> DIVQ_SHIFT);
      q_neg_ff <= a_neg_ff;
      coef_ff  <= coef_in;
      err_ff   <= q_tag_ff.err;
      if (reset) begin
         w_tag_ff.valid <= 1'b0;
         a_tag_ff.valid <= 1'b0;
         q_tag_ff.valid <= 1'b0;
         valid_ff       <= 1'b0;
      end else begin
         w_tag_ff <= in_tag;
         a_tag_ff <= w_tag_ff;
         q_tag_ff <= a_tag_ff;
         valid_ff <= q_tag_ff.valid;
      end
   end

   assign out_valid       = valid_ff;
   assign out_coefficient = coef_ff;
   assign out_index_error = err_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/window_coefficient_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Each index accepted on start returns on rsp_valid once it has passed every stage.
// Throughput: one index per cycle; busy stays low and the result is never held off.
// The 24 stages are the phase divider (5), the two cosine evaluations (15) and scaling (4).
// Reset (synchronous, active high) clears all valid bits and sets Hann, length 1.

module window_coefficient_generator
   import wcg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output      logic                     busy,
   input  wire logic [INDEX_W-1:0]       req_sample_index,
   output      logic                     rsp_valid,
   output      logic signed [COEF_W-1:0] rsp_coefficient,
   output      logic                     rsp_index_error,
   input  wire logic                     csr_write,
   input  wire logic                     csr_index,
   input  wire logic [DATA_W-1:0]        csr_wdata
);

   logic [1:0]        type_ff;
   logic [LEN_W-1:0]  length_ff;
   logic [TURN_W-1:0] turn;
   wcg_tag_type       div_tag;
   wcg_tag_type       trig_tag;
   logic signed [31:0] cos1, cos2;

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff   <= WIN_HANN;
         length_ff <= LEN_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_WINDOW_TYPE: begin
               type_ff <= csr_wdata[1:0];
            end
            default: begin
               // clamp to the longest supported window
               if (csr_wdata > DATA_W'(MAX_LENGTH)) begin
                  length_ff <= LEN_W'(MAX_LENGTH);
               end else begin
                  length_ff <= csr_wdata;
               end
            end
         endcase
      end
   end

   assign busy = 1'b0;

   wcg_phase_div u_div (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (start),
      .sample_index  (req_sample_index),
      .window_length (length_ff),
      .window_type   (type_ff),
      .turn          (turn),
      .tag           (div_tag)
   );

   wcg_trig_pipe u_trig (
      .clock   (clock),
      .reset   (reset),
      .turn    (turn),
      .in_tag  (div_tag),
      .cos1    (cos1),
      .cos2    (cos2),
      .out_tag (trig_tag)
   );

   wcg_combine u_combine (
      .clock           (clock),
      .reset           (reset),
      .cos1            (cos1),
      .cos2            (cos2),
      .in_tag          (trig_tag),
      .out_valid       (rsp_valid),
      .out_coefficient (rsp_coefficient),
      .out_index_error (rsp_index_error)
   );

endmodule

`default_nettype wire
